// File: sv/pinhole_reprojection_residual_macros.svh
// Assertion macros for the pinhole reprojection residual block.
// Included by the top level; needs clk and arst_n in scope.
`ifndef PINHOLE_REPROJECTION_RESIDUAL_MACROS_SVH
`define PINHOLE_REPROJECTION_RESIDUAL_MACROS_SVH
// implication checked on every clock while out of reset
`define PRR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define PRR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// File: sv/prr_pkg.sv
// Package for the pinhole reprojection residual block.
// Payload structs, item kinds, fixed-point constants. No dependencies.
`default_nettype none
package prr_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int WORD_BITS_DEF = 32;
	localparam int SER_DIGIT = 4;

	typedef enum logic [1:0] {
		KIND_FRAME = 2'd0,
		KIND_CAMERA = 2'd1,
		KIND_MEASURE = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		REG_FOCAL_U = 2'd0,
		REG_FOCAL_V = 2'd1,
		REG_CENTER_U = 2'd2,
		REG_CENTER_V = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] entry_index;
		logic signed [31:0] entry_value;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic signed [31:0] observed_u;
		logic signed [31:0] observed_v;
	} in_item_t;

	typedef struct packed {
		logic status;
		logic signed [31:0] camera_x;
		logic signed [31:0] camera_y;
		logic signed [31:0] camera_z;
		logic signed [31:0] normalized_u;
		logic signed [31:0] normalized_v;
		logic signed [31:0] pixel_u;
		logic signed [31:0] pixel_v;
		logic signed [31:0] residual_u;
		logic signed [31:0] residual_v;
		logic [62:0] distance_squared;
	} out_item_t;
endpackage
`default_nettype wire

// File: sv/prr_mul.sv
// Digit-serial signed multiplier for the reprojection block.
// Shift-and-add, SER_DIGIT multiplier bits per cycle; uses prr_pkg.
`default_nettype none
module prr_mul #(
	parameter int AW = 64,
	parameter int BW = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic signed [AW-1:0] a,
	input wire logic signed [BW-1:0] b,
	output logic done,
	output logic signed [AW+BW-1:0] prod
);
	import prr_pkg::*;
	localparam int PW = AW + BW;
	localparam int STEPS = (BW + SER_DIGIT - 1) / SER_DIGIT;
	localparam int CW = $clog2(STEPS + 1);
	localparam int BPAD = STEPS * SER_DIGIT;

	logic [PW-1:0] mc_q;
	logic [BPAD-1:0] mp_q;
	logic [PW-1:0] acc_q;
	logic neg_q;
	logic busy_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] amag;
	logic [BW-1:0] bmag;
	logic [PW-1:0] part;

	assign amag = a[AW-1] ? AW'(-a) : AW'(a);
	assign bmag = b[BW-1] ? BW'(-b) : BW'(b);

	always_comb begin
		part = '0;
		for (int k = 0; k < SER_DIGIT; k++) begin
			if (mp_q[k]) part = part + (mc_q << k);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(STEPS);
			end else if (busy_q) begin
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mc_q <= PW'(amag);
			mp_q <= BPAD'(bmag);
			acc_q <= '0;
			neg_q <= a[AW-1] ^ b[BW-1];
		end else if (busy_q) begin
			acc_q <= acc_q + part;
			mc_q <= mc_q << SER_DIGIT;
			mp_q <= mp_q >> SER_DIGIT;
		end
	end

	assign prod = neg_q ? $signed(-acc_q) : $signed(acc_q);
endmodule
`default_nettype wire

// File: sv/pinhole_reprojection_residual.sv
// Pinhole reprojection residual: pose transforms, depth division, projection.
// Top level; uses prr_pkg, prr_mul and pinhole_reprojection_residual_macros.svh.
//
// One item at a time. Pose writes (kind 0/1) take effect in the accepting cycle
// and give no result, so they can follow back to back; kind 3 is dropped the
// same way. A measure runs 24 serial multiplies for the two pose transforms,
// two restoring divides by the camera depth and four more multiplies for
// projection and distance. Every multiply works in 16 four-bit digit steps
// over the 64-bit internal operands, and each divide works through
// 2*WORD_BITS+FRAC_BITS dividend bits. With a depth that is not positive the
// divides and the last four multiplies are skipped. The single shared
// digit-serial multiplier and the one-bit divider carry out these steps.
// in_stall is high while an item is in flight; a finished result waits in the
// output register while the next item runs, which holds at its last step only
// if the previous result is not yet taken. Poses reset to identity, focal
// lengths to 1.0, principal point to zero.
`default_nettype none
module pinhole_reprojection_residual #(
	parameter int FRAC_BITS = prr_pkg::FRAC_BITS_DEF,
	parameter int WORD_BITS = prr_pkg::WORD_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire prr_pkg::in_item_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output prr_pkg::out_item_t out_data,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [1:0] cfg_index,
	input wire logic [31:0] cfg_data
);
	import prr_pkg::*;
	`include "pinhole_reprojection_residual_macros.svh"

	// internal arithmetic is 64 bit signed, wide enough for any WORD_BITS <= 48
	localparam int IW = 64;
	localparam int PW = 2 * IW;
	localparam int NB = 2 * WORD_BITS + FRAC_BITS; // dividend bits
	localparam int DCW = $clog2(NB + 1);
	localparam logic signed [IW-1:0] SMAX = IW'((65'sd1 <<< (WORD_BITS - 1)) - 1);
	localparam logic signed [IW-1:0] SMIN = -SMAX - IW'(1);
	localparam logic signed [IW-1:0] ONE = IW'(64'sd1 <<< FRAC_BITS);

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_XF = 9'b000000010,
		ST_XW = 9'b000000100,
		ST_DIV = 9'b000001000,
		ST_PRJ = 9'b000010000,
		ST_PW = 9'b000100000,
		ST_DST = 9'b001000000,
		ST_DW = 9'b010000000,
		ST_OUT = 9'b100000000
	} state_t;

	state_t state_q;
	logic signed [31:0] fpose_q [12];
	logic signed [31:0] cpose_q [12];
	logic [30:0] focal_u_q, focal_v_q;
	logic signed [31:0] center_u_q, center_v_q;
	in_item_t item_q;
	logic signed [IW-1:0] vec_q [3]; // current input vector
	logic signed [IW-1:0] res_q [3]; // transformed output
	logic signed [IW-1:0] nrm_q [2];
	logic signed [IW-1:0] pix_q [2];
	logic signed [IW-1:0] rsd_q [2];
	logic signed [PW-1:0] acc_q;
	logic pass_q;       // 0 frame pose, 1 camera pose
	logic [1:0] row_q;
	logic [1:0] col_q;  // 0..2 coefficient, 3 translation
	logic sel_q;        // which of a pair
	logic mstart_q;
	logic signed [IW-1:0] ma_q, mb_q;
	logic mdone;
	logic signed [PW-1:0] mprod;
	// divider
	logic [NB-1:0] dvd_q;
	logic [NB-1:0] quo_q;
	logic [IW:0] rem_q;
	logic [DCW-1:0] dcnt_q;
	logic dneg_q;
	logic signed [IW-1:0] num;
	logic [IW-1:0] nmag;
	logic [IW:0] rsh;
	logic [NB-1:0] qfin;
	logic [IW-1:0] qlim;
	logic signed [IW-1:0] qval;
	logic [62:0] dist_sat;
	logic out_valid_q;
	out_item_t out_q;
	logic [3:0] eidx;
	logic signed [31:0] coef;

	prr_mul #(.AW(IW), .BW(IW)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mstart_q), .a(ma_q), .b(mb_q),
		.done(mdone), .prod(mprod)
	);

	// floor shift by FRAC_BITS then saturate to a WORD_BITS word
	function automatic logic signed [IW-1:0] sat_shr(input logic signed [PW-1:0] v);
		logic signed [PW-1:0] s;
		s = v >>> FRAC_BITS;
		if (s > PW'(SMAX)) return SMAX;
		if (s < PW'(SMIN)) return SMIN;
		return IW'(s);
	endfunction

	function automatic logic signed [IW-1:0] sat_w(input logic signed [IW:0] v);
		if (v > (IW+1)'(SMAX)) return SMAX;
		if (v < (IW+1)'(SMIN)) return SMIN;
		return IW'(v);
	endfunction

	assign eidx = {row_q, col_q};
	assign coef = pass_q ? cpose_q[eidx] : fpose_q[eidx];
	assign num = sel_q ? res_q[1] : res_q[0];
	assign nmag = num[IW-1] ? IW'(-num) : IW'(num);
	assign rsh = {rem_q[IW-1:0], dvd_q[NB-1]};

	// quotient of the last divide step, then clamp and sign
	assign qfin = (rsh >= (IW+1)'(res_q[2])) ? {quo_q[NB-2:0], 1'b1} : {quo_q[NB-2:0], 1'b0};
	assign qlim = dneg_q ? IW'(SMAX) + IW'(1) : IW'(SMAX);
	assign qval = (qfin > NB'(qlim)) ? (dneg_q ? SMIN : SMAX)
		: (dneg_q ? IW'(-IW'(qfin)) : IW'(qfin));

	// sum of squared residuals, clamped to 63 bits
	assign dist_sat = (acc_q > PW'(64'h7FFFFFFFFFFFFFFF))
		? 63'h7FFFFFFFFFFFFFFF : 63'(acc_q);

	assign in_stall = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			mstart_q <= 1'b0;
			focal_u_q <= 31'h10000;
			focal_v_q <= 31'h10000;
			center_u_q <= '0;
			center_v_q <= '0;
			for (int i = 0; i < 12; i++) begin
				fpose_q[i] <= (i == 0 || i == 5 || i == 10) ? 32'(ONE) : '0;
				cpose_q[i] <= (i == 0 || i == 5 || i == 10) ? 32'(ONE) : '0;
			end
		end else begin
			mstart_q <= 1'b0;
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (cfg_valid) begin
				case (reg_idx_t'(cfg_index))
					REG_FOCAL_U: focal_u_q <= cfg_data[30:0];
					REG_FOCAL_V: focal_v_q <= cfg_data[30:0];
					REG_CENTER_U: center_u_q <= cfg_data;
					REG_CENTER_V: center_v_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid && !in_stall) begin
						item_q <= in_data;
						case (kind_t'(in_data.kind))
							KIND_FRAME: begin
								if (in_data.entry_index < 4'd12)
									fpose_q[in_data.entry_index] <= in_data.entry_value;
							end
							KIND_CAMERA: begin
								if (in_data.entry_index < 4'd12)
									cpose_q[in_data.entry_index] <= in_data.entry_value;
							end
							KIND_MEASURE: begin
								vec_q[0] <= IW'(in_data.point_x);
								vec_q[1] <= IW'(in_data.point_y);
								vec_q[2] <= IW'(in_data.point_z);
								pass_q <= 1'b0;
								row_q <= 2'd0;
								col_q <= 2'd3;
								acc_q <= '0;
								state_q <= ST_XF;
							end
							default: ;
						endcase
					end
				end
				ST_XF: begin
					ma_q <= IW'(coef);
					mb_q <= (col_q == 2'd3) ? ONE : vec_q[col_q];
					mstart_q <= 1'b1;
					state_q <= ST_XW;
				end
				ST_XW: begin
					if (mdone) begin
						state_q <= ST_XF;
						if (col_q == 2'd2) begin
							res_q[row_q] <= sat_shr(acc_q + mprod);
							acc_q <= '0;
							col_q <= 2'd3;
							if (row_q == 2'd2) begin
								row_q <= 2'd0;
								if (pass_q) begin
									sel_q <= 1'b0;
									state_q <= ST_DIV;
									dcnt_q <= '0;
								end else begin
									pass_q <= 1'b1;
									vec_q[0] <= res_q[0];
									vec_q[1] <= res_q[1];
									vec_q[2] <= sat_shr(acc_q + mprod);
								end
							end else begin
								row_q <= row_q + 2'd1;
							end
						end else begin
							acc_q <= acc_q + mprod;
							col_q <= (col_q == 2'd3) ? 2'd0 : col_q + 2'd1;
						end
					end
				end
				ST_DIV: begin
					if (res_q[2] <= 0) begin
						// no projection behind or on the camera plane
						state_q <= ST_OUT;
					end else if (dcnt_q == '0) begin
						dvd_q <= NB'({nmag, FRAC_BITS'(0)});
						dneg_q <= num[IW-1];
						rem_q <= '0;
						quo_q <= '0;
						dcnt_q <= DCW'(NB);
					end else begin
						if (rsh >= (IW+1)'(res_q[2])) begin
							rem_q <= rsh - (IW+1)'(res_q[2]);
							quo_q <= {quo_q[NB-2:0], 1'b1};
						end else begin
							rem_q <= rsh;
							quo_q <= {quo_q[NB-2:0], 1'b0};
						end
						dvd_q <= dvd_q << 1;
						dcnt_q <= dcnt_q - DCW'(1);
						// last step: store the quotient, then the v divide or projection
						if (dcnt_q == DCW'(1)) begin
							nrm_q[sel_q] <= qval;
							if (sel_q) begin
								sel_q <= 1'b0;
								state_q <= ST_PRJ;
							end else begin
								sel_q <= 1'b1;
							end
						end
					end
				end
				ST_PRJ: begin
					ma_q <= sel_q ? IW'(focal_v_q) : IW'(focal_u_q);
					mb_q <= nrm_q[sel_q];
					mstart_q <= 1'b1;
					state_q <= ST_PW;
				end
				ST_PW: begin
					if (mdone) begin
						pix_q[sel_q] <= sat_shr(mprod + (PW'(sel_q ? center_v_q : center_u_q)
							<<< FRAC_BITS));
						rsd_q[sel_q] <= sat_w((IW+1)'(sat_shr(mprod +
							(PW'(sel_q ? center_v_q : center_u_q) <<< FRAC_BITS)))
							- (IW+1)'(sel_q ? item_q.observed_v : item_q.observed_u));
						if (sel_q) begin
							sel_q <= 1'b0;
							acc_q <= '0;
							state_q <= ST_DST;
						end else begin
							sel_q <= 1'b1;
							state_q <= ST_PRJ;
						end
					end
				end
				ST_DST: begin
					ma_q <= rsd_q[sel_q];
					mb_q <= rsd_q[sel_q];
					mstart_q <= 1'b1;
					state_q <= ST_DW;
				end
				ST_DW: begin
					if (mdone) begin
						if (sel_q) begin
							acc_q <= acc_q + mprod;
							state_q <= ST_OUT;
						end else begin
							acc_q <= mprod;
							sel_q <= 1'b1;
							state_q <= ST_DST;
						end
					end
				end
				ST_OUT: begin
					// load the output register once the previous result is gone
					if (!out_valid_q || !out_stall) begin
						if (res_q[2] <= 0) begin
							out_q <= '{status: 1'b1, camera_x: 32'(res_q[0]),
								camera_y: 32'(res_q[1]), camera_z: 32'(res_q[2]),
								default: '0};
						end else begin
							out_q <= '{status: 1'b0, camera_x: 32'(res_q[0]),
								camera_y: 32'(res_q[1]), camera_z: 32'(res_q[2]),
								normalized_u: 32'(nrm_q[0]), normalized_v: 32'(nrm_q[1]),
								pixel_u: 32'(pix_q[0]), pixel_v: 32'(pix_q[1]),
								residual_u: 32'(rsd_q[0]), residual_v: 32'(rsd_q[1]),
								distance_squared: dist_sat};
						end
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`PRR_ASSERT_IMP(a_stall_busy, (state_q != ST_IDLE), in_stall, "input taken while busy")
	`PRR_ASSERT_NXT(a_out_hold, (out_valid && out_stall), (out_valid && $stable(out_data)),
		"result dropped under stall")
	`PRR_ASSERT_IMP(a_one_hot, 1'b1, $onehot(state_q), "state not one-hot")
endmodule
`default_nettype wire

// File: verif/prr_checker.sv
// Checker for the pinhole reprojection residual block: watches the item, result and
// register-write channels, predicts each result and compares it field by field.
// Depends on prr_pkg.
`default_nettype none
module prr_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire prr_pkg::in_item_t in_data,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire prr_pkg::out_item_t out_data,
	input wire logic cfg_valid,
	input wire logic cfg_ready,
	input wire logic [1:0] cfg_index,
	input wire logic [31:0] cfg_data,
	output int fail_count,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import prr_pkg::*;

	localparam int FB = 16;
	localparam longint WMAX = 64'sd2147483647;
	localparam longint WMIN = -64'sd2147483648;

	longint frame_m [12];
	longint cam_m [12];
	longint fu, fv, cu, cv;
	out_item_t residual_q [$];

	function automatic longint sat_word(logic signed [127:0] a);
		if (a > 128'(WMAX)) return WMAX;
		if (a < 128'(WMIN)) return WMIN;
		return longint'(a);
	endfunction

	function automatic longint apply_row(longint m [12], int r, longint v [3]);
		logic signed [127:0] acc;
		acc = 128'(m[r*4+3]) <<< FB;
		for (int k = 0; k < 3; k++)
			acc += 128'(m[r*4+k]) * 128'(v[k]);
		return sat_word(acc >>> FB);
	endfunction

	// (n << FB) / d toward zero, clamped to the word
	function automatic longint depth_div(longint n, longint d);
		logic signed [127:0] q;
		q = (128'(n) <<< FB) / 128'(d);
		return sat_word(q);
	endfunction

	function automatic out_item_t project_point(in_item_t it);
		longint p [3], b [3], c [3];
		longint nu, nv, pu, pv, ru, rv;
		logic signed [127:0] d;
		out_item_t r;
		p[0] = it.point_x; p[1] = it.point_y; p[2] = it.point_z;
		for (int k = 0; k < 3; k++) b[k] = apply_row(frame_m, k, p);
		for (int k = 0; k < 3; k++) c[k] = apply_row(cam_m, k, b);
		r = '0;
		r.camera_x = c[0][31:0]; r.camera_y = c[1][31:0]; r.camera_z = c[2][31:0];
		if (c[2] <= 0) begin
			r.status = 1'b1;
			return r;
		end
		nu = depth_div(c[0], c[2]);
		nv = depth_div(c[1], c[2]);
		pu = sat_word((128'(fu) * 128'(nu) + (128'(cu) <<< FB)) >>> FB);
		pv = sat_word((128'(fv) * 128'(nv) + (128'(cv) <<< FB)) >>> FB);
		ru = sat_word(128'(pu) - 128'(longint'(it.observed_u)));
		rv = sat_word(128'(pv) - 128'(longint'(it.observed_v)));
		d = 128'(ru) * 128'(ru) + 128'(rv) * 128'(rv);
		r.normalized_u = nu[31:0]; r.normalized_v = nv[31:0];
		r.pixel_u = pu[31:0]; r.pixel_v = pv[31:0];
		r.residual_u = ru[31:0]; r.residual_v = rv[31:0];
		r.distance_squared = (d > 128'(64'h7fffffffffffffff)) ? 63'h7fffffffffffffff : d[62:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		fail_count++;
	endtask

	task automatic compare_result(out_item_t g, out_item_t e);
		if (g.status !== e.status) report_mismatch("status", g.status, e.status);
		if (g.camera_x !== e.camera_x) report_mismatch("camera_x", g.camera_x, e.camera_x);
		if (g.camera_y !== e.camera_y) report_mismatch("camera_y", g.camera_y, e.camera_y);
		if (g.camera_z !== e.camera_z) report_mismatch("camera_z", g.camera_z, e.camera_z);
		if (g.normalized_u !== e.normalized_u)
			report_mismatch("normalized_u", g.normalized_u, e.normalized_u);
		if (g.normalized_v !== e.normalized_v)
			report_mismatch("normalized_v", g.normalized_v, e.normalized_v);
		if (g.pixel_u !== e.pixel_u) report_mismatch("pixel_u", g.pixel_u, e.pixel_u);
		if (g.pixel_v !== e.pixel_v) report_mismatch("pixel_v", g.pixel_v, e.pixel_v);
		if (g.residual_u !== e.residual_u)
			report_mismatch("residual_u", g.residual_u, e.residual_u);
		if (g.residual_v !== e.residual_v)
			report_mismatch("residual_v", g.residual_v, e.residual_v);
		if (g.distance_squared !== e.distance_squared)
			report_mismatch("distance_squared", g.distance_squared, e.distance_squared);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_count = 0;
			for (int i = 0; i < 12; i++) begin
				frame_m[i] = (i == 0 || i == 5 || i == 10) ? 65536 : 0;
				cam_m[i] = frame_m[i];
			end
			fu = 65536; fv = 65536; cu = 0; cv = 0;
			residual_q.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_FOCAL_U: fu = longint'({1'b0, cfg_data[30:0]});
					REG_FOCAL_V: fv = longint'({1'b0, cfg_data[30:0]});
					REG_CENTER_U: cu = longint'(signed'(cfg_data));
					REG_CENTER_V: cv = longint'(signed'(cfg_data));
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (residual_q.size() == 0)
					report_mismatch("unexpected result transaction", 0, 0);
				else
					compare_result(out_data, residual_q.pop_front());
			end
			if (in_valid && !in_stall) begin
				case (kind_t'(in_data.kind))
					KIND_FRAME: if (in_data.entry_index < 12)
						frame_m[in_data.entry_index] = longint'(in_data.entry_value);
					KIND_CAMERA: if (in_data.entry_index < 12)
						cam_m[in_data.entry_index] = longint'(in_data.entry_value);
					KIND_MEASURE: residual_q.push_back(project_point(in_data));
					default: ;
				endcase
			end
			pending = residual_q.size();
		end
	end
endmodule
`default_nettype wire

// File: verif/tb.sv
// Testbench top for the pinhole reprojection residual block: drives items,
// register writes and result stalls; verdict from prr_checker. Depends on prr_pkg.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import prr_pkg::*;

	localparam int IN_W = $bits(in_item_t);

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	in_item_t in_data;
	out_item_t out_data;
	logic cfg_valid, cfg_ready;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;
	int fail_count, pending;
	int send_idle, recv_stall;   // percent chance per cycle

	pinhole_reprojection_residual i_dut (.*);
	prr_checker i_chk (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// result side: random stall at the configured rate
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_stall);

	// edge values and random values for Q16.16 fields
	function automatic logic [31:0] pick_word();
		case ($urandom_range(9))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'h0;
			3: return 32'hffffffff;
			4, 5: return $urandom;
			default: return 32'(signed'($urandom_range(0, 20 << 16)) - (10 << 16));
		endcase
	endfunction

	// one item transaction; valid held until taken, dropped only on idle cycles
	task automatic send_item(in_item_t it);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic write_pose(kind_t k, int idx, logic [31:0] v);
		in_item_t it;
		it = '{default: '0};
		it.kind = k; it.entry_index = 4'(idx); it.entry_value = v;
		it.point_x = $urandom; it.observed_v = $urandom;
		send_item(it);
	endtask

	task automatic measure(logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic [31:0] ou, logic [31:0] ov);
		in_item_t it;
		it.kind = KIND_MEASURE; it.entry_index = 4'($urandom); it.entry_value = $urandom;
		it.point_x = x; it.point_y = y; it.point_z = z;
		it.observed_u = ou; it.observed_v = ov;
		send_item(it);
	endtask

	// register writes happen only with the block drained
	task automatic write_reg(reg_idx_t r, logic [31:0] v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (700) @(posedge clk);
		cfg_valid <= 1'b1; cfg_index <= r; cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_item();
		int sel;
		sel = $urandom_range(99);
		if (sel < 12)
			write_pose(kind_t'($urandom_range(1)), $urandom_range(15),
				($urandom_range(3) == 0) ? pick_word() :
				32'(signed'($urandom_range(0, 3 << 16)) - (3 << 15)));
		else if (sel < 15) begin
			in_item_t it;
			it = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
			it.kind = KIND_NONE;
			send_item(it);
		end else
			measure(pick_word(), pick_word(),
				($urandom_range(3) == 0) ? pick_word() : 32'($urandom_range(1 << 16, 40 << 16)),
				pick_word(), pick_word());
	endtask

	initial begin
		arst_n = 0; in_valid = 0; in_data = '0; cfg_valid = 0;
		cfg_index = '0; cfg_data = '0;
		send_idle = 0; recv_stall = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: identity poses, field extremes, non-positive depth, pose and register writes, ignored items
		measure(32'h10000, 32'h20000, 32'h10000, 0, 0);
		measure(32'h7fffffff, 32'h80000000, 32'h1, 32'h7fffffff, 32'h80000000);
		measure(32'h80000000, 32'h7fffffff, 32'h1, 32'h80000000, 32'h7fffffff);
		measure(32'h10000, 32'h10000, 32'h0, 0, 0);          // zero depth
		measure(32'h10000, 32'h10000, 32'hffff0000, 0, 0);   // behind the camera
		measure(32'hffffffff, 32'hffffffff, 32'h7fffffff, 32'hffffffff, 0);
		write_pose(KIND_FRAME, 3, 32'h00050000);
		write_pose(KIND_CAMERA, 11, 32'h00020000);
		write_pose(KIND_FRAME, 15, 32'h7fffffff);              // index out of range
		write_pose(KIND_CAMERA, 12, 32'h80000000);
		begin
			in_item_t it;
			it = '1;
			send_item(it);                                     // unknown kind
		end
		measure(32'h30000, 32'hfffd0000, 32'h40000, 32'h12345, 32'h6789a);
		write_reg(REG_FOCAL_U, 32'h7fffffff);
		write_reg(REG_FOCAL_V, 32'h0);
		write_reg(REG_CENTER_U, 32'h80000000);
		write_reg(REG_CENTER_V, 32'h7fffffff);
		measure(32'h10000, 32'hffff0000, 32'h8000, 32'h80000000, 32'h7fffffff);
		measure(32'h7fffffff, 32'h7fffffff, 32'h1, 0, 32'h80000000);
		write_pose(KIND_FRAME, 3, 32'h0);
		write_pose(KIND_CAMERA, 11, 32'h0);

		// random phases across idling mixes and register settings
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 59; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 59; end
				default: begin send_idle = 10; recv_stall = 10; end
			endcase
			write_reg(REG_FOCAL_U, (ph == 0) ? 32'h0 : 32'($urandom_range(1 << 16, 2000 << 16)));
			write_reg(REG_FOCAL_V, (ph == 1) ? 32'hffffffff : $urandom);
			write_reg(REG_CENTER_U, (ph == 2) ? 32'h80000000 : 32'($urandom_range(0, 800 << 16)));
			write_reg(REG_CENTER_V, (ph == 3) ? 32'h7fffffff : 32'($urandom_range(0, 600 << 16)));
			for (int k = 0; k < 12; k++)
				write_pose(kind_t'(k & 1), k, ((k % 5) == 0) ?
					32'($urandom_range(1 << 15, 3 << 15)) :
					32'(signed'($urandom_range(0, 1 << 15)) - (1 << 14)));
			repeat (225) random_item();
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (1000) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#20000000;
		$display("TB_ERROR");
		$finish;
	end
endmodule
`default_nettype wire
